// ----- rtl/header_length_checksum_deframer_unit_macros.svh -----
// Assertion macros used by the deframer top level.
`ifndef HEADER_LENGTH_CHECKSUM_DEFRAMER_UNIT_MACROS_SVH
`define HEADER_LENGTH_CHECKSUM_DEFRAMER_UNIT_MACROS_SVH

// Checks that cons holds in the same cycle whenever ante holds.
`define HLCD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed: same-cycle implication");

// Checks that cons holds in the cycle after ante holds.
`define HLCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed: next-cycle implication");

`endif

// ----- rtl/hlcd_pkg.sv -----
// Shared types, constants and codes of the frame deframer.
`timescale 1ns / 1ps
`default_nettype none

package hlcd_pkg;

    localparam int FRAME_BUFFER = 64;
    localparam int MAX_PAYLOAD  = 32;
    localparam int MAX_RES      = 16;
    localparam int PAYLOAD_BASE = 4;

    localparam int POS_W   = $clog2(FRAME_BUFFER);
    localparam int LEN_W   = 6;
    localparam int WORDS_W = LEN_W - 1;
    localparam int IDX_W   = $clog2(MAX_RES);
    localparam int CMP_W   = ((POS_W > LEN_W) ? POS_W : LEN_W) + 2;

    localparam logic CMD_BYTE  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef enum logic [1:0] {
        KIND_SAMPLE   = 2'd0,
        KIND_FRAME_OK = 2'd1,
        KIND_CSUM_ERR = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        CFG_HEADER_FIRST  = 3'd0,
        CFG_HEADER_SECOND = 3'd1,
        CFG_WAVEFORM_CODE = 3'd2,
        CFG_PLAIN_CODE    = 3'd3,
        CFG_LENGTH_LIMIT  = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic       command;
        logic [7:0] rx_byte;
    } byte_item_t;

    typedef struct packed {
        kind_t              kind;
        logic signed [15:0] sample;
        logic [3:0]         sample_index;
        logic [7:0]         function_word;
        logic               last;
        logic [31:0]        good_frames;
        logic [31:0]        bad_frames;
    } result_item_t;

    typedef struct packed {
        logic             accept;
        logic             rd_en;
        logic             rd_lo;
        logic             cap_hi;
        logic             load_out;
        logic             out_sample;
        logic             out_last;
        logic [IDX_W-1:0] out_idx;
    } hlcd_cmd_t;

    typedef struct packed {
        logic               finish;
        logic               sample_frame;
        logic [WORDS_W-1:0] words;
    } hlcd_status_t;

endpackage

`default_nettype wire

// ----- rtl/hlcd_ctrl.sv -----
// Controller state machine: input acceptance, sample unload sequencing, output valid.
`timescale 1ns / 1ps
`default_nettype none

module hlcd_ctrl
    import hlcd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         byte_valid,
    output logic              byte_stall,
    output logic              result_valid,
    input  wire logic         result_stall,
    input  wire hlcd_status_t status,
    output hlcd_cmd_t         cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_HI,
        S_RD_LO,
        S_PUT,
        S_SINGLE
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;
    logic             slot_free;
    logic             last_word;

    assign slot_free    = !out_valid_reg || !result_stall;
    assign last_word    = ({1'b0, idx_reg} + (IDX_W + 1)'(1)) == (IDX_W + 1)'(status.words);
    assign byte_stall   = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        cmd.out_idx    = idx_reg;
        state_next     = state_reg;
        idx_next       = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.accept = byte_valid;
                if (byte_valid && status.finish)
                begin
                    idx_next = '0;
                    if (status.sample_frame)
                        state_next = S_RD_HI;
                    else
                        state_next = S_SINGLE;
                end
            end
            S_RD_HI:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_RD_LO;
            end
            S_RD_LO:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_lo  = 1'b1;
                cmd.cap_hi = 1'b1;
                state_next = S_PUT;
            end
            S_PUT:
            begin
                if (slot_free)
                begin
                    cmd.load_out   = 1'b1;
                    cmd.out_sample = 1'b1;
                    cmd.out_last   = last_word;
                    if (last_word)
                        state_next = S_IDLE;
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = S_RD_HI;
                    end
                end
            end
            S_SINGLE:
            begin
                if (slot_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.out_last = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.load_out)
            out_valid_next = 1'b1;
        else
            out_valid_next = out_valid_reg && result_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/hlcd_dpath.sv -----
// Datapath: configuration registers, frame parser, running checksum, frame store, counters.
`timescale 1ns / 1ps
`default_nettype none

module hlcd_dpath
    import hlcd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_valid,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [7:0]   cfg_data,
    input  wire byte_item_t   byte_item,
    input  wire hlcd_cmd_t    cmd,
    output hlcd_status_t      status,
    output result_item_t      result_item
);

    // Configuration registers.
    logic [7:0]       hdr_first_reg, hdr_second_reg, wave_code_reg, plain_code_reg;
    logic [LEN_W-1:0] len_limit_reg;

    // Parser state.
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             first_reg, first_next;
    logic             full_reg, full_next;
    logic [7:0]       fn_reg, fn_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [7:0]       sum_reg, sum_next;
    logic [31:0]      good_reg, good_next;
    logic [31:0]      bad_reg, bad_next;

    // Latched facts about the frame that just ended.
    logic               fin_good_reg;
    logic [7:0]         fin_fn_reg;
    logic [WORDS_W-1:0] fin_words_reg;

    logic [7:0]       mem [FRAME_BUFFER];
    logic [7:0]       rd_data_reg;
    logic [7:0]       hi_reg;
    logic [POS_W-1:0] rd_addr;
    result_item_t     item_next;
    result_item_t     item_reg;

    logic [POS_W:0]     pos_wide;
    logic [POS_W:0]     pos_inc;
    logic [7:0]         limit;
    logic [7:0]         rx;
    logic               byte_in;
    logic               frame_end;
    logic               csum_ok;
    logic               finish;
    logic [WORDS_W-1:0] half_len;
    logic [WORDS_W-1:0] words;

    assign rx        = byte_item.rx_byte;
    assign byte_in   = cmd.accept && (byte_item.command == CMD_BYTE);
    assign pos_inc   = {1'b0, pos_reg} + (POS_W + 1)'(1);
    assign limit     = ({2'b00, len_limit_reg} < 8'(MAX_PAYLOAD)) ?
                       {2'b00, len_limit_reg} : 8'(MAX_PAYLOAD);
    assign frame_end = CMP_W'(pos_reg) >= (CMP_W'(len_reg) + CMP_W'(PAYLOAD_BASE));
    assign csum_ok   = (sum_reg == rx);
    assign half_len  = len_reg[LEN_W-1:1];
    assign words     = (WORDS_W'(half_len) > WORDS_W'(MAX_RES)) ?
                       WORDS_W'(MAX_RES) : half_len;

    // Byte parser. The running sum always equals the sum of the stored bytes
    // below the current position, so the checksum never reads the store.
    always_comb
    begin
        pos_wide   = {1'b0, pos_reg};
        first_next = first_reg;
        full_next  = full_reg;
        fn_next    = fn_reg;
        len_next   = len_reg;
        sum_next   = sum_reg;
        finish     = 1'b0;
        if (byte_in)
        begin
            if (full_reg)
            begin
                if (fn_reg != 8'd0)
                begin
                    if (len_reg != '0)
                    begin
                        if (!frame_end)
                        begin
                            pos_wide = pos_inc;
                            sum_next = sum_reg + rx;
                        end
                        else
                        begin
                            finish     = 1'b1;
                            pos_wide   = '0;
                            first_next = 1'b0;
                            full_next  = 1'b0;
                            fn_next    = 8'd0;
                            len_next   = '0;
                            sum_next   = 8'd0;
                        end
                    end
                    else if (rx <= limit)
                    begin
                        len_next = rx[LEN_W-1:0];
                        pos_wide = pos_inc;
                        sum_next = sum_reg + rx;
                    end
                    else
                    begin
                        pos_wide   = '0;
                        first_next = 1'b0;
                        full_next  = 1'b0;
                        fn_next    = 8'd0;
                        sum_next   = 8'd0;
                    end
                end
                else if ((rx == wave_code_reg) || (rx == plain_code_reg))
                begin
                    fn_next  = rx;
                    pos_wide = pos_inc;
                    sum_next = sum_reg + rx;
                end
                else
                begin
                    pos_wide   = '0;
                    first_next = 1'b0;
                    full_next  = 1'b0;
                    sum_next   = 8'd0;
                end
            end
            else if (first_reg)
            begin
                if (rx == hdr_second_reg)
                begin
                    full_next = 1'b1;
                    pos_wide  = pos_inc;
                    sum_next  = sum_reg + rx;
                end
                else if (rx == hdr_first_reg)
                begin
                    // The earlier first header stays at position zero.
                    pos_wide = (POS_W + 1)'(1);
                end
                else
                begin
                    first_next = 1'b0;
                    pos_wide   = '0;
                    sum_next   = 8'd0;
                end
            end
            else
            begin
                if (rx == hdr_first_reg)
                begin
                    first_next = 1'b1;
                    pos_wide   = pos_inc;
                    sum_next   = sum_reg + rx;
                end
                else
                begin
                    pos_wide = '0;
                    sum_next = 8'd0;
                end
            end

            if (pos_wide > (POS_W + 1)'(FRAME_BUFFER - 1))
            begin
                pos_wide   = '0;
                first_next = 1'b0;
                full_next  = 1'b0;
                sum_next   = 8'd0;
            end
        end
        pos_next = pos_wide[POS_W-1:0];
    end

    always_comb
    begin
        good_next = good_reg;
        bad_next  = bad_reg;
        if (cmd.accept && (byte_item.command == CMD_CLEAR))
        begin
            good_next = '0;
            bad_next  = '0;
        end
        else if (finish && csum_ok)
        begin
            if (good_reg != '1)
                good_next = good_reg + 32'd1;
        end
        else if (finish)
        begin
            if (bad_reg != '1)
                bad_next = bad_reg + 32'd1;
        end
    end

    assign status.finish       = finish;
    assign status.sample_frame = csum_ok && (fn_reg == wave_code_reg) && (words != '0);
    assign status.words        = fin_words_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_first_reg  <= 8'd58;
            hdr_second_reg <= 8'd59;
            wave_code_reg  <= 8'd1;
            plain_code_reg <= 8'd2;
            len_limit_reg  <= LEN_W'(32);
            pos_reg        <= '0;
            first_reg      <= 1'b0;
            full_reg       <= 1'b0;
            fn_reg         <= 8'd0;
            len_reg        <= '0;
            sum_reg        <= 8'd0;
            good_reg       <= '0;
            bad_reg        <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_HEADER_FIRST:  hdr_first_reg  <= cfg_data;
                    CFG_HEADER_SECOND: hdr_second_reg <= cfg_data;
                    CFG_WAVEFORM_CODE: wave_code_reg  <= cfg_data;
                    CFG_PLAIN_CODE:    plain_code_reg <= cfg_data;
                    CFG_LENGTH_LIMIT:  len_limit_reg  <= cfg_data[LEN_W-1:0];
                    default:           ;
                endcase
            end
            pos_reg   <= pos_next;
            first_reg <= first_next;
            full_reg  <= full_next;
            fn_reg    <= fn_next;
            len_reg   <= len_next;
            sum_reg   <= sum_next;
            good_reg  <= good_next;
            bad_reg   <= bad_next;
        end
    end

    // Frame store, one write and one registered read per cycle.
    assign rd_addr = POS_W'(PAYLOAD_BASE) + POS_W'({cmd.out_idx, cmd.rd_lo});

    always_ff @(posedge clk)
    begin
        if (byte_in)
            mem[pos_reg] <= rx;
        if (cmd.rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        item_next.function_word = fin_fn_reg;
        item_next.last          = cmd.out_last;
        item_next.good_frames   = good_reg;
        item_next.bad_frames    = bad_reg;
        if (cmd.out_sample)
        begin
            item_next.kind         = KIND_SAMPLE;
            item_next.sample       = $signed({hi_reg, rd_data_reg});
            item_next.sample_index = 4'(cmd.out_idx);
        end
        else
        begin
            item_next.kind         = fin_good_reg ? KIND_FRAME_OK : KIND_CSUM_ERR;
            item_next.sample       = '0;
            item_next.sample_index = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            fin_good_reg  <= csum_ok;
            fin_fn_reg    <= fn_reg;
            fin_words_reg <= words;
        end
        if (cmd.cap_hi)
            hi_reg <= rd_data_reg;
        if (cmd.load_out)
            item_reg <= item_next;
    end

    assign result_item = item_reg;

endmodule

`default_nettype wire

// ----- rtl/header_length_checksum_deframer_unit.sv -----
// Top level of the header, length and checksum frame deframer.
`timescale 1ns / 1ps
`default_nettype none
`include "header_length_checksum_deframer_unit_macros.svh"

// The block takes one received serial byte per input transaction and hunts
// for frames made of two sync bytes, a function word, a length byte, the
// payload and an 8-bit additive checksum over every earlier byte of the
// frame. A byte that does not end a frame, and a counter clear command,
// give no result and leave the input open, so such bytes may arrive every
// cycle. A frame end with a bad checksum, or a good frame that carries no
// samples, gives one result. A good waveform frame with N samples (N at
// most sixteen) gives one result per sample. With a single read port the
// store reads each sample's high byte, then its low byte, then the sample
// is put out; a stall on the result channel holds this. The checksum
// is kept as a running sum while bytes arrive, so it costs nothing at the
// frame end. The result channel has its own register, so the next byte is
// taken while the last result of a frame still waits. Configuration writes
// are always ready and must be issued only while the block is idle. Every
// result carries both saturating frame counters as they stand after the
// transaction that caused it.
module header_length_checksum_deframer_unit
    import hlcd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         byte_valid,
    output logic              byte_stall,
    input  wire byte_item_t   byte_item,
    output logic              result_valid,
    input  wire logic         result_stall,
    output result_item_t      result_item,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [7:0]   cfg_data
);

    hlcd_cmd_t    cmd;
    hlcd_status_t status;

    assign cfg_ready = 1'b1;

    // The controller sequences acceptance and the sample unload.
    hlcd_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd)
    );

    // The datapath holds the parser, the store, the counters and the result register.
    hlcd_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .byte_item   (byte_item),
        .cmd         (cmd),
        .status      (status),
        .result_item (result_item)
    );

    // A byte that ends a frame blocks the input until its results are loaded.
    `HLCD_ASSERT_NEXT(a_finish_blocks, clk, rst_n, (cmd.accept && status.finish), byte_stall)
    // A byte that ends no frame leaves the input open in the next cycle.
    `HLCD_ASSERT_NEXT(a_plain_byte_open, clk, rst_n, (cmd.accept && !status.finish), !byte_stall)
    // A new result is never loaded over one that is still waiting.
    `HLCD_ASSERT_SAME(a_no_overwrite, clk, rst_n, cmd.load_out, !(result_valid && result_stall))

endmodule

`default_nettype wire

// ----- test/header_length_checksum_deframer_unit_test.sv -----
// Self-checking testbench for the header, length and checksum frame deframer.
`timescale 1ns / 1ps

// The bench feeds the deframer one serial byte per input transaction and
// predicts every result transaction with its own copy of the parser state.
// Directed tests come first and cover sample extremes, every frame kind,
// repeated sync bytes, unknown function words, oversize and zero lengths,
// buffer overflow and the counter clear command. Random traffic follows
// under several register settings. Most of it is well-formed frames with
// random content, and the rest is noise, counter clears, truncated frames and bad checksums.
// The sender and the receiver stall at random, in three idling phases.
module header_length_checksum_deframer_unit_test;
    import hlcd_pkg::*;

    localparam logic [7:0] DEFAULT_HEADER_FIRST  = 8'd58;
    localparam logic [7:0] DEFAULT_HEADER_SECOND = 8'd59;
    localparam logic [7:0] DEFAULT_WAVEFORM_CODE = 8'd1;
    localparam logic [7:0] DEFAULT_PLAIN_CODE    = 8'd2;
    localparam logic [7:0] DEFAULT_LENGTH_LIMIT  = 8'd32;

    // Idle cycles after the last result before the block counts as quiet.
    // A byte that ends no frame may still be in flight.
    localparam int SETTLE_CYCLES = 8;

    // This limit leaves a wide margin over the slowest correct run.
    localparam longint RUN_LIMIT_NS = 64'd24_000_000;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         byte_valid = 1'b0;
    logic         byte_stall;
    byte_item_t   byte_item = '0;
    logic         result_valid;
    logic         result_stall = 1'b0;
    result_item_t result_item;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [7:0]   cfg_data = '0;

    header_length_checksum_deframer_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_item    (byte_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Mirror of the register file, updated when a register write is accepted.
    logic [7:0] sync_first  = DEFAULT_HEADER_FIRST;
    logic [7:0] sync_second = DEFAULT_HEADER_SECOND;
    logic [7:0] wave_code   = DEFAULT_WAVEFORM_CODE;
    logic [7:0] plain_code  = DEFAULT_PLAIN_CODE;
    logic [5:0] length_cap  = DEFAULT_LENGTH_LIMIT[5:0];

    // Parser state of the predictor. It holds its reset values at time zero,
    // which matches the single reset at the start of the run.
    logic [7:0]  frame_store [FRAME_BUFFER];
    int          byte_pos = 0;
    bit          got_first = 1'b0;
    bit          in_body = 1'b0;
    logic [7:0]  held_fn = '0;
    int          held_len = 0;
    logic [31:0] good_total = '0;
    logic [31:0] bad_total = '0;

    // Results that the deframer still owes, oldest first.
    result_item_t expected_results [$];

    // Bytes of the frame that a test is assembling.
    logic [7:0] frame_bytes [$];

    int sender_idle_pct = 0;
    int receiver_idle_pct = 0;
    int bytes_sent = 0;
    int mismatch_count = 0;

    initial
    begin
        forever #6 clk = ~clk;
    end

    // The receiver stalls at random. The stall changes only at the falling
    // edge, so it is stable when the result transaction is sampled.
    always @(negedge clk)
        result_stall <= ($urandom_range(99) < receiver_idle_pct);

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Regression FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what, input result_item_t want,
                                   input result_item_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("%0t: %s", $realtime, what);
            $display("  expected kind %0d sample %0d index %0d function %0h last %0b",
                     want.kind, want.sample, want.sample_index, want.function_word,
                     want.last);
            $display("           good %0d bad %0d", want.good_frames, want.bad_frames);
            $display("  actual   kind %0d sample %0d index %0d function %0h last %0b",
                     got.kind, got.sample, got.sample_index, got.function_word, got.last);
            $display("           good %0d bad %0d", got.good_frames, got.bad_frames);
        end
    endtask

    // Every accepted result transaction is compared with the oldest
    // expectation, one field at a time.
    always @(posedge clk)
    begin : result_monitor
        result_item_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("result with no expectation waiting", '0, result_item);
            end
            else
            begin
                want = expected_results.pop_front();
                if (result_item.kind !== want.kind
                    || result_item.sample !== want.sample
                    || result_item.sample_index !== want.sample_index
                    || result_item.function_word !== want.function_word
                    || result_item.last !== want.last
                    || result_item.good_frames !== want.good_frames
                    || result_item.bad_frames !== want.bad_frames)
                begin
                    report_mismatch("result field mismatch", want, result_item);
                end
            end
        end
    end

    // Advances the parser by one accepted byte transaction and queues the
    // results that it should cause.
    task automatic deframe_byte(input byte_item_t item);
        result_item_t found [$];
        result_item_t entry;
        logic [7:0]   b;
        logic [7:0]   sum;
        int           cap;
        int           words;
        if (item.command == CMD_CLEAR)
        begin
            // Counters clear, the hunt itself carries on untouched.
            good_total = '0;
            bad_total = '0;
            return;
        end
        b = item.rx_byte;
        cap = (int'(length_cap) < MAX_PAYLOAD) ? int'(length_cap) : MAX_PAYLOAD;
        frame_store[byte_pos] = b;

        if (in_body)
        begin
            if (held_fn != 8'd0)
            begin
                if (held_len != 0)
                begin
                    if (byte_pos - PAYLOAD_BASE < held_len)
                    begin
                        byte_pos++;
                    end
                    else
                    begin
                        // This byte is the checksum over everything before it.
                        sum = '0;
                        for (int i = 0; i < byte_pos; i++)
                            sum += frame_store[i];
                        entry = '0;
                        entry.function_word = held_fn;
                        if (sum == frame_store[byte_pos])
                        begin
                            if (good_total != '1)
                                good_total++;
                            entry.good_frames = good_total;
                            entry.bad_frames = bad_total;
                            if (held_fn == wave_code)
                            begin
                                words = held_len / 2;
                                if (words > MAX_RES)
                                    words = MAX_RES;
                                for (int i = 0; i < words; i++)
                                begin
                                    entry.kind = KIND_SAMPLE;
                                    entry.sample = {frame_store[PAYLOAD_BASE + 2 * i],
                                                    frame_store[PAYLOAD_BASE + 2 * i + 1]};
                                    entry.sample_index = 4'(i);
                                    found.push_back(entry);
                                end
                            end
                            if (found.size() == 0)
                            begin
                                entry.kind = KIND_FRAME_OK;
                                found.push_back(entry);
                            end
                        end
                        else
                        begin
                            if (bad_total != '1)
                                bad_total++;
                            entry.good_frames = good_total;
                            entry.bad_frames = bad_total;
                            entry.kind = KIND_CSUM_ERR;
                            found.push_back(entry);
                        end
                        byte_pos = 0;
                        got_first = 1'b0;
                        in_body = 1'b0;
                        held_fn = '0;
                        held_len = 0;
                    end
                end
                else if (int'(b) <= cap)
                begin
                    // A zero length is stored too and leaves the next byte
                    // in the length slot.
                    held_len = int'(b);
                    byte_pos++;
                end
                else
                begin
                    byte_pos = 0;
                    got_first = 1'b0;
                    in_body = 1'b0;
                    held_fn = '0;
                end
            end
            else if (b == wave_code || b == plain_code)
            begin
                held_fn = b;
                byte_pos++;
            end
            else
            begin
                byte_pos = 0;
                got_first = 1'b0;
                in_body = 1'b0;
            end
        end
        else if (got_first)
        begin
            if (b == sync_second)
            begin
                in_body = 1'b1;
                byte_pos++;
            end
            else if (b == sync_first)
            begin
                byte_pos = 1;
            end
            else
            begin
                got_first = 1'b0;
                byte_pos = 0;
            end
        end
        else if (b == sync_first)
        begin
            got_first = 1'b1;
            byte_pos++;
        end
        else
        begin
            byte_pos = 0;
        end

        // Running off the end of the store drops the header flags but keeps
        // the held function word and length.
        if (byte_pos > FRAME_BUFFER - 1)
        begin
            byte_pos = 0;
            got_first = 1'b0;
            in_body = 1'b0;
        end

        if (found.size() != 0)
        begin
            found[found.size() - 1].last = 1'b1;
            foreach (found[i])
                expected_results.push_back(found[i]);
        end
    endtask

    // Offers one byte transaction and returns once it is accepted. It starts
    // and ends at a falling edge and leaves valid high, so back-to-back
    // transactions never lower and raise valid in the same time step.
    task automatic send_item(input byte_item_t item);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            byte_valid <= 1'b0;
            @(negedge clk);
        end
        byte_valid <= 1'b1;
        byte_item <= item;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        deframe_byte(item);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_data(input logic [7:0] b);
        byte_item_t item;
        item.command = CMD_BYTE;
        item.rx_byte = b;
        send_item(item);
    endtask

    task automatic send_clear();
        byte_item_t item;
        item.command = CMD_CLEAR;
        item.rx_byte = 8'($urandom_range(255));
        send_item(item);
    endtask

    // Stops the byte stream and waits until every expected result is in and
    // the block has had time to settle.
    task automatic wait_for_results();
        byte_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // Writes all five registers. Only called while the block is quiet.
    task automatic load_settings(input logic [7:0] first, input logic [7:0] second,
                                 input logic [7:0] wave, input logic [7:0] plain,
                                 input logic [7:0] limit);
        logic [7:0] values [5];
        cfg_index_t idx;
        values = '{first, second, wave, plain, limit};
        for (int i = 0; i < 5; i++)
        begin
            idx = cfg_index_t'(i);
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data <= values[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            case (idx)
                CFG_HEADER_FIRST:  sync_first = values[i];
                CFG_HEADER_SECOND: sync_second = values[i];
                CFG_WAVEFORM_CODE: wave_code = values[i];
                CFG_PLAIN_CODE:    plain_code = values[i];
                CFG_LENGTH_LIMIT:  length_cap = values[i][5:0];
                default:           ;
            endcase
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic open_frame(input logic [7:0] fn, input logic [7:0] len);
        frame_bytes = {sync_first, sync_second, fn, len};
    endtask

    task automatic add_payload(input int count);
        repeat (count) frame_bytes.push_back(8'($urandom_range(255)));
    endtask

    task automatic add_checksum(input bit corrupt);
        logic [7:0] sum;
        sum = '0;
        foreach (frame_bytes[i])
            sum += frame_bytes[i];
        if (corrupt)
            sum += 8'($urandom_range(1, 255));
        frame_bytes.push_back(sum);
    endtask

    task automatic send_part(input int lo, input int hi);
        for (int i = lo; i < hi; i++)
            send_data(frame_bytes[i]);
    endtask

    task automatic finish_frame(input bit corrupt);
        add_checksum(corrupt);
        send_part(0, frame_bytes.size());
    endtask

    // Sample extremes, every result kind and the hunt's recovery paths.
    task automatic test_frame_kinds();
        open_frame(wave_code, 8'd4);
        frame_bytes.push_back(8'h80);
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'h7F);
        frame_bytes.push_back(8'hFF);
        finish_frame(1'b0);
        open_frame(plain_code, 8'd1);
        add_payload(1);
        finish_frame(1'b0);
        // A waveform frame with a single payload byte has no whole sample.
        open_frame(wave_code, 8'd1);
        add_payload(1);
        finish_frame(1'b0);
        // Odd length: the trailing payload byte is not decoded.
        open_frame(wave_code, 8'd3);
        add_payload(3);
        finish_frame(1'b0);
        open_frame(plain_code, 8'd2);
        add_payload(2);
        finish_frame(1'b1);
        // An extra first sync byte keeps the hunt alive.
        send_data(sync_first);
        open_frame(plain_code, 8'd2);
        add_payload(2);
        finish_frame(1'b0);
        // Unknown function word, then a length above the limit.
        open_frame(8'h55, 8'd2);
        send_part(0, 3);
        open_frame(wave_code, 8'd33);
        send_part(0, 4);
        open_frame(wave_code, 8'd2);
        add_payload(2);
        finish_frame(1'b0);
    endtask

    // The largest payload unloads sixteen samples in one frame.
    task automatic test_full_payload();
        open_frame(wave_code, 8'd32);
        for (int i = 0; i < 32; i++)
            frame_bytes.push_back((i % 4 == 0) ? 8'hFF : ((i % 4 == 2) ? 8'h00 : 8'(i * 37)));
        finish_frame(1'b0);
        open_frame(wave_code, 8'd32);
        add_payload(32);
        finish_frame(1'b1);
    endtask

    // Zero length bytes keep the parser in the length slot until the store
    // overflows; the next frame then reuses the held function word.
    task automatic test_zero_length_and_overflow();
        open_frame(wave_code, 8'd0);
        frame_bytes.push_back(8'd3);
        add_payload(3);
        finish_frame(1'b0);
        open_frame(wave_code, 8'd0);
        send_part(0, 4);
        repeat (60) send_data(8'd0);
        frame_bytes = {sync_first, sync_second, 8'd4};
        add_payload(4);
        finish_frame(1'b0);
    endtask

    // Clearing the counters resets both counts but not a frame in progress.
    task automatic test_counter_clear();
        send_clear();
        open_frame(plain_code, 8'd3);
        add_payload(3);
        add_checksum(1'b0);
        send_part(0, 5);
        send_clear();
        send_part(5, frame_bytes.size());
        open_frame(wave_code, 8'd2);
        add_payload(2);
        finish_frame(1'b1);
        send_clear();
    endtask

    // Extreme register values, equal sync bytes and equal function codes.
    task automatic test_register_extremes();
        wait_for_results();
        load_settings(8'd0, 8'd255, 8'd255, 8'd1, 8'd0);
        open_frame(wave_code, 8'd1);
        send_part(0, 4);
        open_frame(plain_code, 8'd0);
        frame_bytes.push_back(8'd0);
        add_checksum(1'b0);
        send_part(0, frame_bytes.size());
        wait_for_results();
        load_settings(8'd255, 8'd0, 8'd1, 8'd255, 8'd32);
        open_frame(wave_code, 8'd2);
        frame_bytes.push_back(8'hFF);
        frame_bytes.push_back(8'hFF);
        finish_frame(1'b0);
        open_frame(plain_code, 8'd5);
        add_payload(5);
        finish_frame(1'b0);
        wait_for_results();
        load_settings(8'h5A, 8'h5A, 8'd7, 8'd7, 8'd17);
        open_frame(8'd7, 8'd17);
        add_payload(17);
        finish_frame(1'b0);
        open_frame(8'd7, 8'd18);
        send_part(0, 4);
        open_frame(8'd7, 8'd6);
        add_payload(6);
        finish_frame(1'b0);
    endtask

    // Random stream of mostly well-formed frames with random content. The
    // sender pauses once halfway until every owed result has come back.
    task automatic run_traffic(input int byte_goal);
        int         start;
        int         pick;
        int         cap;
        int         len;
        logic [7:0] fn;
        bit         paused;
        start = bytes_sent;
        paused = 1'b0;
        while (bytes_sent - start < byte_goal)
        begin
            if (!paused && bytes_sent - start >= byte_goal / 2)
            begin
                wait_for_results();
                paused = 1'b1;
            end
            cap = (int'(length_cap) < MAX_PAYLOAD) ? int'(length_cap) : MAX_PAYLOAD;
            pick = $urandom_range(99);
            fn = (pick < 55) ? wave_code
                 : ((pick < 88) ? plain_code : 8'($urandom_range(255)));
            pick = $urandom_range(99);
            len = (pick < 75) ? $urandom_range((cap < 8) ? cap : 8, 0)
                  : ((pick < 92) ? $urandom_range(cap, 0) : $urandom_range(255));
            open_frame(fn, 8'(len));
            add_payload((len <= MAX_PAYLOAD + 4) ? len : 3);
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                finish_frame($urandom_range(99) < 12);
            end
            else if (pick < 80)
            begin
                repeat ($urandom_range(4, 1)) send_data(8'($urandom_range(255)));
            end
            else if (pick < 86)
            begin
                send_data(sync_first);
            end
            else if (pick < 90)
            begin
                send_clear();
            end
            else
            begin
                // Truncated frame: whatever follows is parsed as its continuation.
                send_part(0, $urandom_range(frame_bytes.size() - 1, 1));
            end
        end
    endtask

    task automatic test_random_traffic(input int sender_pct, input int receiver_pct);
        logic [7:0] first;
        logic [7:0] wave;
        sender_idle_pct = sender_pct;
        receiver_idle_pct = receiver_pct;
        wait_for_results();
        load_settings(DEFAULT_HEADER_FIRST, DEFAULT_HEADER_SECOND, DEFAULT_WAVEFORM_CODE,
                      DEFAULT_PLAIN_CODE, DEFAULT_LENGTH_LIMIT);
        run_traffic(6);
        wait_for_results();
        first = 8'($urandom_range(255));
        wave = 8'($urandom_range(255, 1));
        load_settings(first,
                      ($urandom_range(3) == 0) ? first : 8'($urandom_range(255)),
                      wave,
                      ($urandom_range(9) == 0) ? wave : 8'($urandom_range(255, 1)),
                      ($urandom_range(9) == 0) ? 8'($urandom_range(32))
                                               : 8'($urandom_range(32, 4)));
        run_traffic(8);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        sender_idle_pct = 9;
        receiver_idle_pct = 59;
        load_settings(DEFAULT_HEADER_FIRST, DEFAULT_HEADER_SECOND, DEFAULT_WAVEFORM_CODE,
                      DEFAULT_PLAIN_CODE, DEFAULT_LENGTH_LIMIT);
        test_frame_kinds();
        test_full_payload();
        test_zero_length_and_overflow();
        test_counter_clear();
        test_register_extremes();

        test_random_traffic(9, 59);
        test_random_traffic(59, 9);
        test_random_traffic(0, 0);

        wait_for_results();
        if (expected_results.size() != 0)
            mismatch_count += expected_results.size();
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
